FILE: hw/rtl/slot_event_scheduler_defines.svh
// Assertion macros for the port-level checker of the slot event scheduler.
`ifndef SLOT_EVENT_SCHEDULER_DEFINES_SVH
`define SLOT_EVENT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/slotsch_pkg.sv
// Shared types and codes of the slot event scheduler.
package slotsch_pkg;

  localparam logic OP_SCHED = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [1:0] KIND_SCHED    = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;
  localparam logic [1:0] KIND_NONE_DUE = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [31:0] target;
    logic [7:0]  tag;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } back_state_t;

endpackage

FILE: hw/rtl/slotsch_front.sv
// Request intake: computes the target time and queues requests for the back end.
module slotsch_front
  import slotsch_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_now_cycle,
  input  logic [31:0] in_delay,
  input  logic [7:0]  in_event_tag,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    cmd_in.op     = in_opcode;
    cmd_in.now    = in_now_cycle;
    cmd_in.target = (in_opcode == OP_SCHED) ? (in_now_cycle + in_delay) : 32'd0;
    cmd_in.tag    = in_event_tag;
    wr_ptr_nxt    = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt    = cmd_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt       = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: hw/rtl/slotsch_back.sv
// Slot table with schedule and scan-and-fire sequencer driving the result strobe.
module slotsch_back
  import slotsch_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_fired_tag,
  output logic [31:0] out_lateness,
  output logic        out_last
);

  localparam int IW = $clog2(SLOTS);

  typedef struct packed {
    logic [IW-1:0] slot;
    logic [7:0]    tag;
    logic [31:0]   late;
  } pend_t;

  back_state_t      state_r, state_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [31:0]      target_r [SLOTS];
  logic [7:0]       tag_r [SLOTS];
  cmd_t             cur_r, cur_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  pend_t            pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             wr_en;
  logic             free_found;
  logic [IW-1:0]    free_idx;
  logic [32:0]      diff;
  logic             due;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [2:0]       out_slot_r, out_slot_nxt;
  logic [7:0]       out_tag_r, out_tag_nxt;
  logic [31:0]      out_late_r, out_late_nxt;
  logic             out_last_r, out_last_nxt;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_slot      = out_slot_r;
  assign out_fired_tag = out_tag_r;
  assign out_lateness  = out_late_r;
  assign out_last      = out_last_r;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // One subtractor per scan step; its borrow is the unsigned compare.
  assign diff = {1'b0, cur_r.now} - {1'b0, target_r[idx_r]};
  assign due  = active_r[idx_r] && !diff[32];

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    cmd_pop       = 1'b0;
    wr_en         = 1'b0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_tag_nxt   = out_tag_r;
    out_late_nxt  = out_late_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          if (cmd.op == OP_SCHED) begin
            out_valid_nxt = 1'b1;
            out_tag_nxt   = 8'd0;
            out_late_nxt  = 32'd0;
            out_last_nxt  = 1'b1;
            if (free_found) begin
              wr_en                = 1'b1;
              active_nxt[free_idx] = 1'b1;
              out_kind_nxt         = KIND_SCHED;
              out_slot_nxt         = 3'(free_idx);
            end else begin
              out_kind_nxt = KIND_FULL;
              out_slot_nxt = 3'd0;
            end
          end else begin
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (due) begin
          active_nxt[idx_r] = 1'b0;
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIRED;
            out_slot_nxt  = 3'(pend_r.slot);
            out_tag_nxt   = pend_r.tag;
            out_late_nxt  = pend_r.late;
            out_last_nxt  = 1'b0;
          end
          pend_nxt.slot = idx_r;
          pend_nxt.tag  = tag_r[idx_r];
          pend_nxt.late = diff[31:0];
          pend_v_nxt    = 1'b1;
        end
        if (idx_r == IW'(SLOTS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        if (pend_v_r) begin
          out_kind_nxt = KIND_FIRED;
          out_slot_nxt = 3'(pend_r.slot);
          out_tag_nxt  = pend_r.tag;
          out_late_nxt = pend_r.late;
        end else begin
          out_kind_nxt = KIND_NONE_DUE;
          out_slot_nxt = 3'd0;
          out_tag_nxt  = 8'd0;
          out_late_nxt = 32'd0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    pend_r     <= pend_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_tag_r  <= out_tag_nxt;
    out_late_r <= out_late_nxt;
    out_last_r <= out_last_nxt;
    if (wr_en) begin
      target_r[free_idx] <= cmd.target;
      tag_r[free_idx]    <= cmd.tag;
    end
  end

endmodule

FILE: hw/rtl/slot_event_scheduler.sv
// Top level of the timed event slot table scheduler.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+-------------------------------
//   request | in_opcode, in_now_cycle,       | taken when start is high and
//           | in_delay, in_event_tag         | busy is low
//   result  | out_kind, out_slot,            | out_valid strobe, one cycle
//           | out_fired_tag, out_lateness,   | per result, out_last marks the
//           | out_last                       | final result of a request
//
// A schedule request is queued, popped by the back end once idle, and its result registered.
// A check request occupies the back end through ST_SCAN and ST_DONE: one slot compare per
// cycle through a single 33-bit subtractor, then the final result from ST_DONE.
// Reset clears the active flags at once; there is no clearing pass.
// A two-entry queue sits between intake and back end; busy is high while it is full.
module slot_event_scheduler
  import slotsch_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_now_cycle,
  input  logic [31:0] in_delay,
  input  logic [7:0]  in_event_tag,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_slot,
  output logic [7:0]  out_fired_tag,
  output logic [31:0] out_lateness,
  output logic        out_last
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  slotsch_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_now_cycle (in_now_cycle),
    .in_delay     (in_delay),
    .in_event_tag (in_event_tag),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  slotsch_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_slot      (out_slot),
    .out_fired_tag (out_fired_tag),
    .out_lateness  (out_lateness),
    .out_last      (out_last)
  );

endmodule

FILE: hw/rtl/slotsch_checker.sv
// Port-level checks of the slot event scheduler and their bind to the top level.
`include "slot_event_scheduler_defines.svh"

module slotsch_checker
  import slotsch_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_kind,
  input logic [2:0]  out_slot,
  input logic [7:0]  out_fired_tag,
  input logic [31:0] out_lateness,
  input logic        out_last
);

  `SES_ASSERT_NOW(a_single_is_last,
    out_valid && (out_kind != KIND_FIRED), out_last,
    "A non-fire result must be the last one of its request.")
  `SES_ASSERT_NOW(a_empty_fields_zero,
    out_valid && (out_kind == KIND_FULL || out_kind == KIND_NONE_DUE),
    out_slot == 3'd0 && out_fired_tag == 8'd0 && out_lateness == 32'd0,
    "A full or nothing-due result must carry zero fields.")
  `SES_ASSERT_NOW(a_sched_fields_zero,
    out_valid && (out_kind == KIND_SCHED), out_fired_tag == 8'd0 && out_lateness == 32'd0,
    "A schedule result must carry zero tag and lateness.")
  `SES_ASSERT_NEXT(a_fire_run_continues,
    out_valid && !out_last, !out_valid || out_kind == KIND_FIRED,
    "A fire result that is not last can only be followed by another fire result.")
  `SES_ASSERT_NEXT(a_busy_needs_request,
    !busy && !start, !busy,
    "Busy must not rise without a request being taken.")

endmodule

bind slot_event_scheduler slotsch_checker u_slotsch_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_kind      (out_kind),
  .out_slot      (out_slot),
  .out_fired_tag (out_fired_tag),
  .out_lateness  (out_lateness),
  .out_last      (out_last)
);

FILE: dv/slot_event_scheduler_checker.sv
// Checker for the slot event scheduler: predicts the results of each request and compares them.
`timescale 1ns / 1ps

module slot_event_scheduler_checker
  import slotsch_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_now_cycle,
  input  logic [31:0] in_delay,
  input  logic [7:0]  in_event_tag,
  input  logic        out_valid,
  input  logic [1:0]  out_kind,
  input  logic [2:0]  out_slot,
  input  logic [7:0]  out_fired_tag,
  input  logic [31:0] out_lateness,
  input  logic        out_last,
  output int          mismatches,
  output int          awaited
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [7:0]  tag;
    logic [31:0] lateness;
    logic        last;
  } slot_result_t;

  slot_result_t expected_results[$];
  logic         armed[SLOTS];
  logic [31:0]  due_cycle[SLOTS];
  logic [7:0]   event_tag[SLOTS];

  function automatic slot_result_t make_result(logic [1:0] kind, logic [2:0] slot,
                                               logic [7:0] tag, logic [31:0] late,
                                               logic last);
    slot_result_t r;
    r.kind = kind;
    r.slot = slot;
    r.tag = tag;
    r.lateness = late;
    r.last = last;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic schedule_or_fire(input logic op, input logic [31:0] now,
                                  input logic [31:0] dly, input logic [7:0] tag);
    int  fired;
    bit  placed;
    fired = 0;
    placed = 1'b0;
    if (op == OP_SCHED) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!placed && !armed[i]) begin
          armed[i] = 1'b1;
          due_cycle[i] = now + dly;
          event_tag[i] = tag;
          expected_results.push_back(make_result(KIND_SCHED, 3'(i), 8'd0, 32'd0, 1'b1));
          placed = 1'b1;
        end
      end
      if (!placed) begin
        expected_results.push_back(make_result(KIND_FULL, 3'd0, 8'd0, 32'd0, 1'b1));
      end
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        if (armed[i] && now >= due_cycle[i]) begin
          armed[i] = 1'b0;
          expected_results.push_back(make_result(KIND_FIRED, 3'(i), event_tag[i],
                                                 now - due_cycle[i], 1'b0));
          fired++;
        end
      end
      if (fired == 0) begin
        expected_results.push_back(make_result(KIND_NONE_DUE, 3'd0, 8'd0, 32'd0, 1'b1));
      end else begin
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
    end
  endtask

  task automatic compare_result();
    slot_result_t exp_r;
    if (expected_results.size() == 0) begin
      report($sformatf("result with nothing expected: kind %0d slot %0d", out_kind, out_slot));
    end else begin
      exp_r = expected_results.pop_front();
      if (out_kind !== exp_r.kind)
        report($sformatf("kind is %0d, expected %0d", out_kind, exp_r.kind));
      if (out_slot !== exp_r.slot)
        report($sformatf("slot is %0d, expected %0d", out_slot, exp_r.slot));
      if (out_fired_tag !== exp_r.tag)
        report($sformatf("fired tag is 0x%0h, expected 0x%0h", out_fired_tag, exp_r.tag));
      if (out_lateness !== exp_r.lateness)
        report($sformatf("lateness is 0x%0h, expected 0x%0h", out_lateness, exp_r.lateness));
      if (out_last !== exp_r.last)
        report($sformatf("last is %0b, expected %0b", out_last, exp_r.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        armed[i] = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (out_valid) begin
        compare_result();
      end
      if (start && !busy) begin
        schedule_or_fire(in_opcode, in_now_cycle, in_delay, in_event_tag);
      end
    end
    awaited <= expected_results.size();
  end

endmodule

FILE: dv/slot_event_scheduler_tb.sv
// Testbench top for the slot event scheduler: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module slot_event_scheduler_tb;
  import slotsch_pkg::*;

  localparam int SLOTS = 8;
  localparam int RANDOM_REQS = 360;
  localparam int CALM_TAIL = 60;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_opcode = OP_SCHED;
  logic [31:0] in_now_cycle = '0;
  logic [31:0] in_delay = '0;
  logic [7:0]  in_event_tag = '0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [2:0]  out_slot;
  logic [7:0]  out_fired_tag;
  logic [31:0] out_lateness;
  logic        out_last;
  int          mismatches;
  int          awaited;
  int          quiet_cycles = 0;

  always #1 clk = ~clk;

  slot_event_scheduler #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_now_cycle(in_now_cycle), .in_delay(in_delay),
    .in_event_tag(in_event_tag), .out_valid(out_valid), .out_kind(out_kind),
    .out_slot(out_slot), .out_fired_tag(out_fired_tag), .out_lateness(out_lateness),
    .out_last(out_last)
  );

  slot_event_scheduler_checker #(.SLOTS(SLOTS)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_now_cycle(in_now_cycle), .in_delay(in_delay),
    .in_event_tag(in_event_tag), .out_valid(out_valid), .out_kind(out_kind),
    .out_slot(out_slot), .out_fired_tag(out_fired_tag), .out_lateness(out_lateness),
    .out_last(out_last), .mismatches(mismatches), .awaited(awaited)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(input logic op, input logic [31:0] now,
                              input logic [31:0] dly, input logic [7:0] tag);
    in_opcode <= op;
    in_now_cycle <= now;
    in_delay <= dly;
    in_event_tag <= tag;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic [31:0] clock_base;
    logic [31:0] now;
    logic [31:0] dly;
    int          pick;
    int          span;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, full table of wrapped and extreme targets, overflow, flush, due edge.
    send_request(OP_CHECK, 32'd0, 32'd0, 8'd0);
    send_request(OP_SCHED, 32'd0, 32'd0, 8'h00);
    send_request(OP_SCHED, 32'hFFFF_FFFF, 32'd1, 8'hFF);
    send_request(OP_SCHED, 32'd0, 32'hFFFF_FFFF, 8'hA5);
    send_request(OP_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h5A);
    send_request(OP_SCHED, 32'd1000, 32'd10, 8'h01);
    send_request(OP_SCHED, 32'h8000_0000, 32'd0, 8'h80);
    send_request(OP_SCHED, 32'h7FFF_FFFF, 32'd1, 8'h7F);
    send_request(OP_SCHED, 32'd0, 32'd12345, 8'h3C);
    send_request(OP_SCHED, 32'd55, 32'd66, 8'hC3);
    send_request(OP_CHECK, 32'd0, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_SCHED, 32'd20, 32'd0, 8'h11);
    send_request(OP_SCHED, 32'd0, 32'd0, 8'h22);
    send_request(OP_CHECK, 32'hFFFF_FFFF, 32'd0, 8'd0);
    send_request(OP_SCHED, 32'd100, 32'd50, 8'h33);
    send_request(OP_CHECK, 32'd149, 32'd0, 8'd0);
    send_request(OP_CHECK, 32'd150, 32'd0, 8'd0);
    send_request(OP_CHECK, 32'hFFFF_FFFF, 32'd0, 8'd0);

    // A running cycle counter drives most requests, with occasional jumps and flushes.
    clock_base = $urandom_range(0, 4000);
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n < RANDOM_REQS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      clock_base = clock_base + $urandom_range(0, 24);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if (pick < 3) now = 32'hFFFF_FFFF;
        else if (pick < 6) now = $urandom;
        else now = clock_base;
        send_request(OP_CHECK, now, $urandom, 8'($urandom_range(0, 255)));
      end else begin
        now = (pick < 92) ? clock_base : $urandom;
        span = $urandom_range(0, 9);
        if (span < 2) dly = 32'd0;
        else if (span < 8) dly = $urandom_range(1, 150);
        else dly = $urandom;
        send_request(OP_SCHED, now, dly, 8'($urandom_range(0, 255)));
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/slotsch_pkg.sv
hw/rtl/slotsch_front.sv
hw/rtl/slotsch_back.sv
hw/rtl/slot_event_scheduler.sv
hw/rtl/slotsch_checker.sv
dv/slot_event_scheduler_checker.sv
dv/slot_event_scheduler_tb.sv
